// File: hdl/srdiv_pkg.sv
// Shared types and constants for the signed restoring divider.
package srdiv_pkg;

    // Width of the dividend, divisor and quotient fields at the ports
    localparam int FIELD_W = 64;

    // Status from the iterative divide unit to the sequencer
    typedef struct packed {
        logic busy;   // steps still in progress
        logic done;   // one-cycle pulse after the last step
    } t_div_status;

endpackage

// File: hdl/srdiv_core.sv
// Iterative unsigned restoring divide unit: one quotient bit per cycle.
module srdiv_core #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DATA_WIDTH-1:0]     i_num,
    input  logic [DATA_WIDTH-1:0]     i_den,
    output logic [DATA_WIDTH-1:0]     o_quo,
    output srdiv_pkg::t_div_status    o_status
);
    import srdiv_pkg::*;

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    logic [DATA_WIDTH-1:0] r_num, n_num;
    logic [DATA_WIDTH-1:0] r_den;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [DATA_WIDTH-1:0] r_quo, n_quo;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DATA_WIDTH:0]   w_shift;
    logic [DATA_WIDTH:0]   w_diff;
    logic                  w_take;

    // Shared shift/subtract: bring down the next numerator bit, trial subtract
    always_comb begin
        w_shift = {r_rem, r_num[DATA_WIDTH-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_take  = ~w_diff[DATA_WIDTH];
        n_rem   = w_take ? w_diff[DATA_WIDTH-1:0] : w_shift[DATA_WIDTH-1:0];
        n_quo   = {r_quo[DATA_WIDTH-2:0], w_take};
        n_num   = {r_num[DATA_WIDTH-2:0], 1'b0};
    end

    // Step counter and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Payload registers need no reset
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo           = r_quo;
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule

// File: hdl/signed_restoring_divider.sv
// Top level of the signed restoring divider: sequencer, sign handling, output register.
//
// Input channel: i_valid / o_stall carry a request of i_dividend and i_divisor
// (signed 64-bit fields); it is taken at a rising edge with i_valid high and
// o_stall low. Only the low DATA_WIDTH bits are used, read as two's complement.
// Output channel: o_valid / i_stall carry o_quotient, truncated toward zero and
// sign-extended from DATA_WIDTH bits. A zero divisor gives 0; the most negative
// value over -1 saturates to the largest positive value.
// Path: a request taken in idle has its magnitudes formed, runs through the
// shift/subtract unit, has that unit's finish detected and its sign fixed, and
// then enters the output register, where o_valid rises.
// Issue: a new request is taken only after the last one has left the finish
// state, as the single shift/subtract unit gives one quotient bit per cycle;
// o_stall is high while a request is in progress.
// Receiver stall: o_quotient holds while i_stall is high; a new request may be
// taken and worked on meanwhile, its result waiting for the output register.
// Reset (i_rst_n low, synchronous): the sequencer returns to idle, the output
// is emptied and any request in progress is dropped.
module signed_restoring_divider #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [srdiv_pkg::FIELD_W-1:0] i_dividend,
    input  logic signed [srdiv_pkg::FIELD_W-1:0] i_divisor,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [srdiv_pkg::FIELD_W-1:0] o_quotient
);
    import srdiv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAG,
        S_RUN,
        S_FIN
    } t_state;

    t_state                r_state;
    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] r_b;
    logic                  r_neg_diff;
    logic                  r_den_zero;
    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_quotient;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_neg_a;
    logic                  w_neg_b;
    logic [DATA_WIDTH-1:0] w_mag_a;
    logic [DATA_WIDTH-1:0] w_mag_b;
    logic                  w_start;
    logic [DATA_WIDTH-1:0] w_core_quo;
    t_div_status           w_status;
    logic signed [DATA_WIDTH-1:0] w_res;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_start    = (r_state == S_MAG);

    // Magnitudes of the captured operands
    always_comb begin
        w_neg_a = r_a[DATA_WIDTH-1];
        w_neg_b = r_b[DATA_WIDTH-1];
        w_mag_a = w_neg_a ? (~r_a + 1'b1) : r_a;
        w_mag_b = w_neg_b ? (~r_b + 1'b1) : r_b;
    end

    srdiv_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_num    (w_mag_a),
        .i_den    (w_mag_b),
        .o_quo    (w_core_quo),
        .o_status (w_status)
    );

    // Sign fix-up: zero divisor, negation, saturation of the one overflow case
    always_comb begin
        if (r_den_zero) begin
            w_res = '0;
        end else if (r_neg_diff) begin
            w_res = signed'(~w_core_quo + 1'b1);
        end else if (w_core_quo[DATA_WIDTH-1]) begin
            w_res = signed'({1'b0, {(DATA_WIDTH-1){1'b1}}});
        end else begin
            w_res = signed'(w_core_quo);
        end
    end

    // Sequencer with operand capture and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // drained result; the finish state refills the register itself
            if (r_out_valid && !i_stall && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_a     <= i_dividend[DATA_WIDTH-1:0];
                        r_b     <= i_divisor[DATA_WIDTH-1:0];
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_neg_diff <= w_neg_a ^ w_neg_b;
                    r_den_zero <= (r_b == '0);
                    r_state    <= S_RUN;
                end
                S_RUN: begin
                    if (w_status.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_quotient  <= FIELD_W'(w_res);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_quotient = signed'(r_quotient);

`ifndef SYNTHESIS
    // The divide unit only finishes while the sequencer waits for it
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.done |-> (r_state == S_RUN))
        else $error("divide unit finished outside the run state");

    // The divide unit is never stepping while the sequencer is idle
    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_status.busy)
        else $error("divide unit busy while idle");

    // A taken request moves straight to magnitude formation
    a_accept_to_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_MAG))
        else $error("request taken but sequencer did not start");

    // Operands of like sign never give a negative quotient
    a_like_sign_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && !r_neg_diff && w_out_free) |=> !o_quotient[FIELD_W-1])
        else $error("negative quotient from operands of like sign");
`endif

endmodule
